// ===== rtl/sfsv_pkg.sv =====
// ----------------------------------------------------------------------------
// sfsv_pkg: shared definitions for the frame byte-sum validator
// Widths, frame lengths, signature bytes and status codes used by the core
// and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sfsv_pkg;

    // byte stream and result widths
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int SUM_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int OUT_CNT_W     = 32;
    localparam int OUT_FIELDS_W  = STATUS_W + 2 * OUT_CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // default counter width
    localparam int COUNTER_BITS_DEF = 32;

    // byte positions within a frame
    localparam logic [IDX_W-1:0] IDX_SIG0     = 6'd0;
    localparam logic [IDX_W-1:0] IDX_SIG1     = 6'd1;
    localparam logic [IDX_W-1:0] IDX_SIG2     = 6'd2;
    localparam logic [IDX_W-1:0] IDX_SUM_END  = 6'd17;
    localparam logic [IDX_W-1:0] IDX_CHK_HI   = 6'd18;
    localparam logic [IDX_W-1:0] IDX_CHK_LO   = 6'd19;
    localparam logic [IDX_W-1:0] IDX_LSUM_END = 6'd31;
    localparam logic [IDX_W-1:0] IDX_CHK_LONG = 6'd32;
    localparam logic [IDX_W-1:0] IDX_SAT      = 6'd34;

    // index of the final byte for each accepted frame length (20 and 33)
    localparam logic [IDX_W-1:0] IDX_LAST_SHORT = 6'd19;
    localparam logic [IDX_W-1:0] IDX_LAST_LONG  = 6'd32;

    // signature bytes
    localparam logic [BYTE_W-1:0] SIG0_MASK = 8'hfe;
    localparam logic [BYTE_W-1:0] SIG0_VAL  = 8'h6c;
    localparam logic [BYTE_W-1:0] SIG1_VAL  = 8'h80;
    localparam logic [BYTE_W-1:0] SIG2_VAL  = 8'h04;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LEN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SIG   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LONG  = 3'd4;

endpackage : sfsv_pkg

`default_nettype wire

// ===== rtl/spi_frame_sum_validator_core.sv =====
// ----------------------------------------------------------------------------
// spi_frame_sum_validator_core: frame byte-sum validator
// Checks signature, short and long checksums and length of received frames
// and reports a status with good and bad frame counts per frame.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: one frame byte per request in s_tdata, byte zero first,
//   s_tlast high on the final byte of the transaction.
//   Output stream m_*: one request per frame, issued for the byte that
//   carried s_tlast, holding the status and the good and bad frame counts
//   including that frame. Other bytes produce no output.
//   Result: the final byte taken sits in the input register, and the result
//   register loads from it when the pipeline advances, raising m_tvalid.
//   Throughput: one byte per cycle while no result is stalled, set by the
//   single pass of the sum adders and byte compares between the input
//   register and the state/result registers.
//   Reset: frame position, sum, first error and both counters clear; both
//   streams go idle.
//   Stall: while m_tready is low with a result pending, the pipeline holds;
//   one further byte is still taken into the input register, then s_tready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_frame_sum_validator_core
    import sfsv_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] byte_value
    input  wire logic                   s_tlast,   // last_byte
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // [2:0] status, [34:3] good_frames,
                                                   // [66:35] bad_frames, [71:67] zero
);

    localparam int CNT_EXT_W = (COUNTER_BITS > OUT_CNT_W) ? COUNTER_BITS : OUT_CNT_W;

    // input register
    logic                       in_valid_reg;
    logic [BYTE_W-1:0]          in_byte_reg;
    logic                       in_last_reg;

    // frame state
    logic [IDX_W-1:0]           idx_reg,   idx_next;
    logic [SUM_W-1:0]           sum_reg,   sum_next;
    logic [STATUS_W-1:0]        ferr_reg,  ferr_next;
    logic [COUNTER_BITS-1:0]    ok_cnt_reg,  ok_cnt_next;
    logic [COUNTER_BITS-1:0]    err_cnt_reg, err_cnt_next;

    // result register
    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [OUT_CNT_W-1:0]       out_good_reg,   out_good_next;
    logic [OUT_CNT_W-1:0]       out_bad_reg,    out_bad_next;

    logic                       advance;
    logic                       process;
    logic [STATUS_W-1:0]        byte_err;
    logic                       len_ok;
    logic [STATUS_W-1:0]        status;
    logic [CNT_EXT_W-1:0]       ok_ext;
    logic [CNT_EXT_W-1:0]       err_ext;

    // pipeline moves whenever the result slot is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance;

    // per-byte checks and sum update
    always_comb
    begin
        byte_err = ST_OK;
        sum_next = sum_reg;
        if (idx_reg == IDX_SIG0)
        begin
            if ((in_byte_reg & SIG0_MASK) != SIG0_VAL)
                byte_err = ST_SIG;
            sum_next = sum_reg + SUM_W'(in_byte_reg);
        end
        else if (idx_reg == IDX_SIG1)
        begin
            if (in_byte_reg != SIG1_VAL)
                byte_err = ST_SIG;
            sum_next = sum_reg + SUM_W'(in_byte_reg);
        end
        else if (idx_reg == IDX_SIG2)
        begin
            if (in_byte_reg != SIG2_VAL)
                byte_err = ST_SIG;
            sum_next = sum_reg + SUM_W'(in_byte_reg);
        end
        else if (idx_reg <= IDX_SUM_END)
        begin
            sum_next = sum_reg + SUM_W'(in_byte_reg);
        end
        else if (idx_reg == IDX_CHK_HI)
        begin
            if (in_byte_reg != sum_reg[SUM_W-1:BYTE_W])
                byte_err = ST_SHORT;
        end
        else if (idx_reg == IDX_CHK_LO)
        begin
            if (in_byte_reg != sum_reg[BYTE_W-1:0])
                byte_err = ST_SHORT;
            // sum carries on with the expected high half and this byte
            sum_next = sum_reg + SUM_W'(sum_reg[SUM_W-1:BYTE_W]) + SUM_W'(in_byte_reg);
        end
        else if (idx_reg <= IDX_LSUM_END)
        begin
            sum_next = sum_reg + SUM_W'(in_byte_reg);
        end
        else if (idx_reg == IDX_CHK_LONG)
        begin
            if (in_byte_reg != sum_reg[BYTE_W-1:0])
                byte_err = ST_LONG;
        end
    end

    // frame status, length check has priority
    always_comb
    begin
        ferr_next = (ferr_reg == ST_OK) ? byte_err : ferr_reg;
        len_ok    = (idx_reg == IDX_LAST_SHORT) || (idx_reg == IDX_LAST_LONG);
        status    = len_ok ? ferr_next : ST_LEN;
        idx_next  = (idx_reg < IDX_SAT) ? idx_reg + IDX_W'(1) : idx_reg;
    end

    // counter update and result fields
    always_comb
    begin
        ok_cnt_next  = ok_cnt_reg;
        err_cnt_next = err_cnt_reg;
        if (status == ST_OK)
            ok_cnt_next = ok_cnt_reg + COUNTER_BITS'(1);
        else
            err_cnt_next = err_cnt_reg + COUNTER_BITS'(1);
        ok_ext          = CNT_EXT_W'(ok_cnt_next);
        err_ext         = CNT_EXT_W'(err_cnt_next);
        out_status_next = status;
        out_good_next   = ok_ext[OUT_CNT_W-1:0];
        out_bad_next    = err_ext[OUT_CNT_W-1:0];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // frame state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sum_reg     <= '0;
            ferr_reg    <= ST_OK;
            ok_cnt_reg  <= '0;
            err_cnt_reg <= '0;
        end
        else if (process)
        begin
            if (in_last_reg)
            begin
                idx_reg     <= '0;
                sum_reg     <= '0;
                ferr_reg    <= ST_OK;
                ok_cnt_reg  <= ok_cnt_next;
                err_cnt_reg <= err_cnt_next;
            end
            else
            begin
                idx_reg  <= idx_next;
                sum_reg  <= sum_next;
                ferr_reg <= ferr_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && in_last_reg)
        begin
            out_status_reg <= out_status_next;
            out_good_reg   <= out_good_next;
            out_bad_reg    <= out_bad_next;
        end
    end

    // output stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_bad_reg, out_good_reg, out_status_reg};

endmodule : spi_frame_sum_validator_core

`default_nettype wire

// ===== rtl/sfsv_checker.sv =====
// ----------------------------------------------------------------------------
// sfsv_checker: port-level checks for the frame byte-sum validator
// Watches the stream ports of the core over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsv_checker
    import sfsv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic                   s_tlast,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result request holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result request changed while stalled");

    // input back-pressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

    // reported status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] == ST_OK) || (m_tdata[STATUS_W-1:0] == ST_LEN)
                  || (m_tdata[STATUS_W-1:0] == ST_SIG) || (m_tdata[STATUS_W-1:0] == ST_SHORT)
                  || (m_tdata[STATUS_W-1:0] == ST_LONG))
        else $error("undefined status code");

    // a result only rises after a final byte has been taken and passed the
    // input register, or after a final byte was offered while the input stalled
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2)
                         || $past(s_tlast && !s_tready, 1))
        else $error("result without a final byte");

endmodule : sfsv_checker

bind spi_frame_sum_validator_core sfsv_checker u_sfsv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
